/* rtl/prc_pkg.sv */
// ----------------------------------------------------------------------------
// prc_pkg
// Shared constants, types and rule-compare helpers for the rule classifier.
// ----------------------------------------------------------------------------
`default_nettype none
package prc_pkg;

  localparam int MAX_RULES   = 1024;
  localparam int PROTO_SLOTS = 4;
  localparam int RULE_W      = $clog2(MAX_RULES);
  localparam int ADDR_W      = RULE_W + 2;
  localparam int CNT_W       = RULE_W + 1;
  localparam logic [7:0] ANY_PROTO  = 8'hff;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_IN    = 2'd1,
    OP_OUT   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    FK_RUNT  = 2'd0,
    FK_NONIP = 2'd1,
    FK_TRUNC = 2'd2,
    FK_IPV4  = 2'd3
  } frame_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]  iface_id;
    logic [47:0] src_mac;
    logic [1:0]  frame_kind;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  ip_proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  tcp_ctl;
    logic        outbound;
  } frame_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [5:0] l;
    l = (len > 6'd32) ? 6'd32 : len;
    return (l == 6'd0) ? 32'd0 : (32'hffff_ffff << (6'd32 - l));
  endfunction

  function automatic logic proto_listed(input logic [63:0] w2, input logic [7:0] proto);
    logic hit;
    logic stop;
    hit  = (w2[7:0] == ANY_PROTO);
    stop = 1'b0;
    for (int k = 0; k < PROTO_SLOTS; k++) begin
      if (!stop) begin
        if (w2[8*k +: 8] == ANY_PROTO) stop = 1'b1;
        else if (w2[8*k +: 8] == proto) hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic rule_hits(input logic [63:0] w0, input logic [63:0] w1,
                                     input logic [63:0] w2, input logic [63:0] w3,
                                     input frame_t f);
    logic ok;
    logic [31:0] dm;
    logic [31:0] sm;
    logic sp_set;
    logic dp_set;
    sp_set = w3[60];
    dp_set = w3[61];
    dm = prefix_mask(w3[59:54]);
    sm = prefix_mask(w3[53:48]);
    ok = 1'b1;
    if (w0[52] && (w0[51:48] != f.iface_id)) ok = 1'b0;
    if (!f.outbound && !w0[53]) ok = 1'b0;
    if (f.outbound && !w0[54]) ok = 1'b0;
    if (w0[55] && (w0[47:0] != f.src_mac)) ok = 1'b0;
    if (f.frame_kind == FK_IPV4) begin
      if ((w1[31:0] & dm) != (f.dst_ip & dm)) ok = 1'b0;
      if ((w1[63:32] & sm) != (f.src_ip & sm)) ok = 1'b0;
      if (!proto_listed(w2, f.ip_proto)) ok = 1'b0;
      if ((f.ip_proto == PROTO_TCP) || (f.ip_proto == PROTO_UDP)) begin
        if (sp_set && (w3[15:0] != f.sport)) ok = 1'b0;
        if (dp_set && (w3[31:16] != f.dport)) ok = 1'b0;
        if ((f.ip_proto == PROTO_TCP) && (w3[39:32] != (f.tcp_ctl & w3[47:40])))
          ok = 1'b0;
      end else if (sp_set || dp_set) begin
        ok = 1'b0;
      end
    end else if (f.frame_kind != FK_TRUNC) begin
      if ((w3[53:48] != 6'd0) || (w3[59:54] != 6'd0) || sp_set || dp_set) ok = 1'b0;
      if ((w3[47:40] != 8'd0) || (w2[7:0] != ANY_PROTO)) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

/* rtl/prc_ram.sv */
// ----------------------------------------------------------------------------
// prc_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module prc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry when we is set; rdata always returns the addressed entry's old contents
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* rtl/packet_rule_classifier.sv */
// ----------------------------------------------------------------------------
// packet_rule_classifier
// Ordered rule table scan, last match wins, quick match ends the scan.
// ----------------------------------------------------------------------------
// Write, runt or unused opcode: ST_IDLE goes to ST_DONE, which loads the
//   result register. Classify: ST_LOAD, then ST_WAIT and ST_CMP per rule; one
//   64-bit word is read per cycle from the single-port rule RAM and each rule
//   is compared in ST_CMP. One transaction at a time; the next is taken once
//   the result register is free. Reset (synchronous, rst_n low) clears control
//   state and rules_in_use; rule RAM contents are undefined until written.
`default_nettype none
module packet_rule_classifier
  import prc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_rules_in_use,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [11:0] in_rule_addr,
  input  wire logic [63:0] in_rule_word,
  input  wire logic [3:0]  in_iface_id,
  input  wire logic [47:0] in_src_mac,
  input  wire logic [1:0]  in_frame_kind,
  input  wire logic [31:0] in_src_ip,
  input  wire logic [31:0] in_dst_ip,
  input  wire logic [7:0]  in_ip_proto,
  input  wire logic [15:0] in_sport,
  input  wire logic [15:0] in_dport,
  input  wire logic [7:0]  in_tcp_ctl,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_drop,
  output logic             out_matched,
  output logic [9:0]       out_deciding_rule
);

  state_t            state_r, state_nxt;
  logic [10:0]       rules_in_use_r;
  frame_t            frame_r;
  logic [CNT_W-1:0]  limit_r;
  logic [CNT_W-1:0]  rule_r;
  logic [1:0]        word_r;
  logic [63:0]       w0_r, w1_r, w2_r;
  logic              act_r, hit_r;
  logic [RULE_W-1:0] dec_r;
  logic              out_valid_r;
  logic              out_drop_r, out_hit_r;
  logic [RULE_W-1:0] out_dec_r;

  logic              in_acc;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [63:0]       ram_rdata;
  logic [CNT_W-1:0]  rule_inc;
  logic              rule_hit;
  logic              scan_end;
  logic              res_ld;
  logic              res_drop, res_hit;
  logic [RULE_W-1:0] res_dec;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE) || out_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign rule_inc  = rule_r + 1'b1;

  // write rule words straight from the input transaction
  assign ram_we = in_acc && (opcode_t'(in_opcode) == OP_WRITE)
                  && ({1'b0, in_rule_addr} < 13'(MAX_RULES * 4));

  // idle takes the input address; in the compare cycle, start fetching word 0 of the next rule
  always_comb begin
    if (state_r == ST_IDLE)     ram_addr = in_rule_addr[ADDR_W-1:0];
    else if (state_r == ST_CMP) ram_addr = {rule_inc[RULE_W-1:0], 2'd0};
    else                        ram_addr = {rule_r[RULE_W-1:0], word_r};
  end

  prc_ram #(.WIDTH(64), .DEPTH(MAX_RULES * 4)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_rule_word),
    .rdata (ram_rdata)
  );

  // word 3 arrives in ST_CMP; compare the full rule
  assign rule_hit = rule_hits(w0_r, w1_r, w2_r, ram_rdata, frame_r);
  assign scan_end = (rule_inc >= limit_r) || (rule_hit && ram_rdata[63]);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (((opcode_t'(in_opcode) == OP_IN) || (opcode_t'(in_opcode) == OP_OUT))
              && (frame_kind_t'(in_frame_kind) != FK_RUNT)) state_nxt = ST_LOAD;
          else state_nxt = ST_DONE;
        end
      end
      ST_LOAD: state_nxt = (limit_r == '0) ? ST_DONE : ST_WAIT;
      ST_WAIT: if (word_r == 2'd3) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = scan_end ? ST_DONE : ST_WAIT;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: result load
  always_comb begin
    res_ld   = 1'b0;
    res_drop = act_r;
    res_hit  = hit_r;
    res_dec  = dec_r;
    unique case (state_r)
      ST_DONE: res_ld = 1'b1;
      default: res_ld = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      rules_in_use_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) rules_in_use_r <= cfg_rules_in_use;
      if (res_ld) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          frame_r <= '{iface_id: in_iface_id, src_mac: in_src_mac,
                       frame_kind: in_frame_kind, src_ip: in_src_ip,
                       dst_ip: in_dst_ip, ip_proto: in_ip_proto,
                       sport: in_sport, dport: in_dport,
                       tcp_ctl: in_tcp_ctl,
                       outbound: (opcode_t'(in_opcode) == OP_OUT)};
          limit_r <= (rules_in_use_r > 11'(MAX_RULES)) ? CNT_W'(MAX_RULES)
                                                         : CNT_W'(rules_in_use_r);
          act_r   <= ((opcode_t'(in_opcode) == OP_IN) || (opcode_t'(in_opcode) == OP_OUT))
                     && (frame_kind_t'(in_frame_kind) == FK_RUNT);
          hit_r   <= 1'b0;
          dec_r   <= '0;
          rule_r  <= '0;
          word_r  <= '0;
        end
      end
      ST_LOAD: word_r <= 2'd1;
      ST_WAIT: begin
        // capture previous word, advance address
        case (word_r)
          2'd1:    w0_r <= ram_rdata;
          2'd2:    w1_r <= ram_rdata;
          default: w2_r <= ram_rdata;
        endcase
        if (word_r != 2'd3) word_r <= word_r + 2'd1;
        else word_r <= 2'd0;
      end
      ST_CMP: begin
        if (rule_hit) begin
          act_r <= ram_rdata[62];
          hit_r <= 1'b1;
          dec_r <= rule_r[RULE_W-1:0];
        end
        rule_r <= rule_inc;
        word_r <= 2'd1;
      end
      default: ;
    endcase
    if (res_ld) begin
      out_drop_r <= res_drop;
      out_hit_r  <= res_hit;
      out_dec_r  <= res_dec;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drop          = out_drop_r;
  assign out_matched       = out_hit_r;
  assign out_deciding_rule = out_dec_r;

endmodule
`default_nettype wire
